### design/rational_arith_unit_defines.svh
// ----------------------------------------------------------------------------
// rational_arith_unit_defines
// Assertion macros shared by the rational arithmetic unit.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITH_UNIT_DEFINES_SVH
`define RATIONAL_ARITH_UNIT_DEFINES_SVH
// Concurrent check: label, clock, reset, property body, message
`define RAU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Concurrent check that also runs during reset
`define RAU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

### design/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Types and codes shared by the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;
   localparam int unsigned PROD_W = 64;

   typedef enum logic [1:0] {
      FUNC_ADD = 2'd0,
      FUNC_SUB = 2'd1,
      FUNC_MUL = 2'd2,
      FUNC_DIV = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_DIV0 = 2'd1,
      STAT_OVF  = 2'd2
   } status_type;

   // Classified job handed from front to back
   typedef struct packed {
      logic              neg;
      logic              zero_den;
      logic [PROD_W-1:0] mag;
      logic [PROD_W-1:0] den;
   } job_type;
endpackage

### design/rau_front.sv
// ----------------------------------------------------------------------------
// rau_front
// Accepts words, cross-multiplies over several cycles, normalizes the sign
// and emits a job with magnitudes of numerator and denominator.
// ----------------------------------------------------------------------------
module rau_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_func,
   input  logic signed [31:0]    req_left_num,
   input  logic [30:0]           req_left_den,
   input  logic signed [31:0]    req_right_num,
   input  logic [30:0]           req_right_den,
   output logic                  job_valid,
   input  logic                  job_ready,
   output rau_pkg::job_type      job_data
);
   import rau_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_SIGN, S_OUT
   } state_type;

   state_type          state_ff, state_in;
   func_type           func_ff, func_in;
   logic signed [32:0] ln_ff, ld_ff, rn_ff, rd_ff;
   logic signed [32:0] ln_in, ld_in, rn_in, rd_in;
   logic signed [32:0] ma, mb;
   logic signed [65:0] prod;
   logic signed [65:0] p_ff, p_in;
   logic signed [65:0] n_ff, n_in, d_ff, d_in;
   job_type            job_ff, job_in;
   logic signed [65:0] nn, dd;

   assign prod = ma * mb;

   always_comb begin
      ma = ln_ff;
      mb = rd_ff;
      case (state_ff)
         S_MUL1: begin
            ma = ln_ff;
            mb = (func_ff == FUNC_MUL) ? rn_ff : rd_ff;
         end
         S_MUL2: begin
            ma = (func_ff == FUNC_DIV) ? rn_ff : ld_ff;
            mb = (func_ff == FUNC_DIV) ? ld_ff : rd_ff;
         end
         S_MUL3: begin
            ma = rn_ff;
            mb = ld_ff;
         end
         default: begin
            ma = ln_ff;
            mb = rd_ff;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      func_in  = func_ff;
      ln_in = ln_ff; ld_in = ld_ff; rn_in = rn_ff; rd_in = rd_ff;
      p_in = p_ff; n_in = n_ff; d_in = d_ff;
      job_in = job_ff;
      nn = n_ff;
      dd = d_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in  = func_type'(req_func);
               ln_in    = {req_left_num[31], req_left_num};
               ld_in    = {2'b00, req_left_den};
               rn_in    = {req_right_num[31], req_right_num};
               rd_in    = {2'b00, req_right_den};
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            p_in     = prod;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            n_in     = p_ff;
            d_in     = prod;
            state_in = (func_ff == FUNC_ADD || func_ff == FUNC_SUB) ? S_MUL3 : S_SIGN;
         end
         S_MUL3: begin
            n_in     = (func_ff == FUNC_SUB) ? n_ff - prod : n_ff + prod;
            state_in = S_SIGN;
         end
         S_SIGN: begin
            if (d_ff < 0) begin
               nn = -n_ff;
               dd = -d_ff;
            end
            job_in.zero_den = (d_ff == '0);
            job_in.neg      = nn < 0;
            job_in.mag      = nn[63:0];
            if (nn < 0) job_in.mag = 64'(-nn);
            job_in.den      = dd[63:0];
            state_in        = S_OUT;
         end
         S_OUT: begin
            if (job_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      func_ff <= func_in;
      ln_ff <= ln_in; ld_ff <= ld_in; rn_ff <= rn_in; rd_ff <= rd_in;
      p_ff <= p_in; n_ff <= n_in; d_ff <= d_in;
      job_ff <= job_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign job_valid = (state_ff == S_OUT);
   assign job_data  = job_ff;
endmodule

### design/rau_queue.sv
// ----------------------------------------------------------------------------
// rau_queue
// Two-entry queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module rau_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  rau_pkg::job_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output rau_pkg::job_type out_data
);
   import rau_pkg::*;

   job_type    mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wr_ff] <= in_data;
   end
endmodule

### design/rau_back.sv
// ----------------------------------------------------------------------------
// rau_back
// Reduces a job by a binary GCD, divides both parts by it with a restoring
// divider, checks the range and holds the result word.
// ----------------------------------------------------------------------------
`include "rational_arith_unit_defines.svh"
module rau_back #(
   parameter int unsigned WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   output logic                job_ready,
   input  rau_pkg::job_type    job_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_res_num,
   output logic [30:0]         rsp_res_den,
   output logic [1:0]          rsp_status
);
   import rau_pkg::*;

   localparam logic [PROD_W-1:0] LIM = PROD_W'((64'd1 << (WIDTH - 1)) - 64'd1);

   typedef enum logic [2:0] {
      S_IDLE, S_GCD, S_DIVN, S_DIVD, S_DONE, S_OUT
   } state_type;

   state_type          state_ff;
   logic               neg_ff;
   logic [PROD_W-1:0]  mag_ff, den_ff, a_ff, b_ff, g_ff;
   logic [6:0]         shift_ff;
   logic [PROD_W-1:0]  q_ff, r_ff, dv_ff, qn_ff;
   logic [6:0]         cnt_ff;
   logic [PROD_W:0]    rtry;
   logic [PROD_W-1:0]  amb, bma;
   logic signed [31:0] num_ff;
   logic [30:0]        den_out_ff;
   status_type         stat_ff;

   assign rtry = {r_ff, q_ff[PROD_W-1]} - {1'b0, g_ff};
   assign amb  = a_ff - b_ff;
   assign bma  = b_ff - a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (job_valid) begin
                  neg_ff   <= job_data.neg;
                  mag_ff   <= job_data.mag;
                  den_ff   <= job_data.den;
                  a_ff     <= job_data.mag;
                  b_ff     <= job_data.den;
                  shift_ff <= '0;
                  if (job_data.zero_den) begin
                     num_ff     <= '0;
                     den_out_ff <= 31'd1;
                     stat_ff    <= STAT_DIV0;
                     state_ff   <= S_OUT;
                  end else if (job_data.mag == '0) begin
                     num_ff     <= '0;
                     den_out_ff <= 31'd1;
                     stat_ff    <= STAT_OK;
                     state_ff   <= S_OUT;
                  end else begin
                     state_ff <= S_GCD;
                  end
               end
            end
            S_GCD: begin
               if (a_ff == b_ff) begin
                  g_ff     <= a_ff << shift_ff[5:0];
                  q_ff     <= mag_ff;
                  r_ff     <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_DIVN;
               end else if (!a_ff[0] && !b_ff[0]) begin
                  a_ff     <= a_ff >> 1;
                  b_ff     <= b_ff >> 1;
                  shift_ff <= shift_ff + 7'd1;
               end else if (!a_ff[0]) begin
                  a_ff <= a_ff >> 1;
               end else if (!b_ff[0]) begin
                  b_ff <= b_ff >> 1;
               end else if (a_ff > b_ff) begin
                  a_ff <= amb >> 1;
               end else begin
                  b_ff <= bma >> 1;
               end
            end
            S_DIVN, S_DIVD: begin
               if (!rtry[PROD_W]) begin
                  r_ff <= rtry[PROD_W-1:0];
                  q_ff <= {q_ff[PROD_W-2:0], 1'b1};
               end else begin
                  r_ff <= {r_ff[PROD_W-2:0], q_ff[PROD_W-1]};
                  q_ff <= {q_ff[PROD_W-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'(PROD_W - 1)) begin
                  cnt_ff <= '0;
                  if (state_ff == S_DIVN) begin
                     qn_ff    <= rtry[PROD_W] ? {q_ff[PROD_W-2:0], 1'b0}
                                              : {q_ff[PROD_W-2:0], 1'b1};
                     q_ff     <= den_ff;
                     r_ff     <= '0;
                     state_ff <= S_DIVD;
                  end else begin
                     dv_ff    <= rtry[PROD_W] ? {q_ff[PROD_W-2:0], 1'b0}
                                              : {q_ff[PROD_W-2:0], 1'b1};
                     state_ff <= S_DONE;
                  end
               end
            end
            S_DONE: begin
               if (qn_ff > LIM || dv_ff > LIM) begin
                  num_ff     <= '0;
                  den_out_ff <= 31'd1;
                  stat_ff    <= STAT_OVF;
               end else begin
                  num_ff     <= neg_ff ? 32'(-qn_ff) : qn_ff[31:0];
                  den_out_ff <= dv_ff[30:0];
                  stat_ff    <= STAT_OK;
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (rsp_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign job_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = (state_ff == S_OUT);
   assign rsp_res_num = num_ff;
   assign rsp_res_den = den_out_ff;
   assign rsp_status  = stat_ff;

   `RAU_ASSERT(a_den_nonzero, clock, reset,
      rsp_valid |-> rsp_res_den != '0, "result denominator is zero")
   `RAU_ASSERT(a_err_zero, clock, reset,
      (rsp_valid && rsp_status != STAT_OK) |-> (rsp_res_num == '0 && rsp_res_den == 31'd1),
      "error result is not 0/1")
   `RAU_ASSERT(a_hold, clock, reset,
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_res_num)),
      "result dropped while stalled")
   `RAU_ASSERT(a_one_side, clock, reset,
      !(job_ready && rsp_valid), "back takes a job while holding a result")
   `RAU_ASSERT_ALWAYS(a_reset_idle, clock,
      reset |=> !rsp_valid, "result valid right after reset")
endmodule

### design/rational_arith_unit.sv
// ----------------------------------------------------------------------------
// rational_arith_unit
// Adds, subtracts, multiplies or divides two fractions and reduces the result.
// ----------------------------------------------------------------------------
// channel | prefix | direction | words
// request | req_   | in        | func, two fractions
// result  | rsp_   | out       | reduced fraction, status
// Front: one 33x33 multiplier; add and subtract take an extra product step.
// Back: zero and divide-by-zero words go straight to the result; others run
// a binary GCD, then two restoring divisions, numerator then denominator;
// the back sets the rate.
// A two-entry queue lets the front take the next word while the back works.
// Synchronous reset clears FSMs and queue pointers; stalls hold every word.
module rational_arith_unit #(
   parameter int unsigned WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic signed [31:0] req_left_num,
   input  logic [30:0]        req_left_den,
   input  logic signed [31:0] req_right_num,
   input  logic [30:0]        req_right_den,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_res_num,
   output logic [30:0]        rsp_res_den,
   output logic [1:0]         rsp_status
);
   import rau_pkg::*;

   logic    fj_valid, fj_ready, bj_valid, bj_ready;
   job_type fj_data, bj_data;

   rau_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_func, .req_left_num,
      .req_left_den, .req_right_num, .req_right_den,
      .job_valid(fj_valid), .job_ready(fj_ready), .job_data(fj_data)
   );

   rau_queue u_queue (
      .clock, .reset,
      .in_valid(fj_valid), .in_ready(fj_ready), .in_data(fj_data),
      .out_valid(bj_valid), .out_ready(bj_ready), .out_data(bj_data)
   );

   rau_back #(.WIDTH(WIDTH)) u_back (
      .clock, .reset,
      .job_valid(bj_valid), .job_ready(bj_ready), .job_data(bj_data),
      .rsp_valid, .rsp_ready, .rsp_res_num, .rsp_res_den, .rsp_status
   );
endmodule

### tb/sv/rational_arith_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arith_unit_checker
// Watches both channels of the rational arithmetic unit, computes the reduced
// fraction for every accepted request word and compares every result word.
// ----------------------------------------------------------------------------
module rational_arith_unit_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic signed [31:0] req_left_num,
   input  logic [30:0]        req_left_den,
   input  logic signed [31:0] req_right_num,
   input  logic [30:0]        req_right_den,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_res_num,
   input  logic [30:0]        rsp_res_den,
   input  logic [1:0]         rsp_status,
   output int                 fail_count,
   output int                 pending,
   output int                 result_count
);
   import rau_pkg::*;

   localparam int EXP_DEPTH = 1024;

   typedef struct {
      logic signed [31:0] num;
      logic [30:0]        den;
      status_type         stat;
   } fraction_word;

   fraction_word exp_mem [EXP_DEPTH];
   int           wr_idx = 0;
   int           rd_idx = 0;

   function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
      logic [63:0] t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic fraction_word reduce_fraction(logic [1:0] fn,
         logic signed [31:0] ln, logic [30:0] ld, logic signed [31:0] rn, logic [30:0] rd);
      fraction_word w;
      logic signed [63:0] n, d, lnx, ldx, rnx, rdx;
      logic [63:0] mag, den, g;
      logic neg;
      lnx = ln; rnx = rn;
      ldx = {33'd0, ld}; rdx = {33'd0, rd};
      case (func_type'(fn))
         FUNC_ADD: begin n = lnx * rdx + rnx * ldx; d = ldx * rdx; end
         FUNC_SUB: begin n = lnx * rdx - rnx * ldx; d = ldx * rdx; end
         FUNC_MUL: begin n = lnx * rnx; d = ldx * rdx; end
         default:  begin n = lnx * rdx; d = ldx * rnx; end
      endcase
      w.num = 0; w.den = 1; w.stat = STAT_OK;
      if (d == 0) begin
         w.stat = STAT_DIV0;
         return w;
      end
      if (d < 0) begin
         d = -d;
         n = -n;
      end
      neg = n < 0;
      mag = neg ? -n : n;
      den = d;
      g = gcd64(mag, den);
      mag = mag / g;
      den = den / g;
      if (mag > 64'h7FFF_FFFF || den > 64'h7FFF_FFFF) begin
         w.stat = STAT_OVF;
         return w;
      end
      w.num = neg ? -mag[31:0] : mag[31:0];
      w.den = den[30:0];
      return w;
   endfunction

   assign pending = wr_idx - rd_idx;

   always @(posedge clock) begin
      fraction_word e;
      if (reset) begin
         fail_count <= 0;
         result_count <= 0;
         wr_idx <= 0;
         rd_idx <= 0;
      end else begin
         if (req_valid && req_ready) begin
            exp_mem[wr_idx % EXP_DEPTH] <= reduce_fraction(req_func, req_left_num,
                                                           req_left_den, req_right_num,
                                                           req_right_den);
            wr_idx <= wr_idx + 1;
         end
         if (rsp_valid && rsp_ready) begin
            result_count <= result_count + 1;
            if (wr_idx == rd_idx) begin
               if (fail_count < 10) $display("unexpected result word %0d/%0d st %0d",
                                             rsp_res_num, rsp_res_den, rsp_status);
               fail_count <= fail_count + 1;
            end else begin
               e = exp_mem[rd_idx % EXP_DEPTH];
               rd_idx <= rd_idx + 1;
               if (e.num !== rsp_res_num || e.den !== rsp_res_den || e.stat !== rsp_status) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %0d/%0d st %0d, got %0d/%0d st %0d",
                              e.num, e.den, e.stat, rsp_res_num, rsp_res_den, rsp_status);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

### tb/sv/rational_arith_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arith_unit_tb
// Drives directed and random fraction pairs through the rational arithmetic
// unit with random gaps and stalls on both channels, and reports the verdict.
// ----------------------------------------------------------------------------
module rational_arith_unit_tb;
   import rau_pkg::*;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic [1:0]         req_func = 0;
   logic signed [31:0] req_left_num = 0;
   logic [30:0]        req_left_den = 1;
   logic signed [31:0] req_right_num = 0;
   logic [30:0]        req_right_den = 1;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic signed [31:0] rsp_res_num;
   logic [30:0]        rsp_res_den;
   logic [1:0]         rsp_status;
   int                 fail_count, pending, result_count;
   int                 cycle_count = 0;
   int                 sent = 0;
   localparam int      CYCLE_LIMIT = 1500000;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   rational_arith_unit DUT (.*);

   rational_arith_unit_checker checker_inst (.*);

   function automatic int gap_len();
      if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) return $urandom_range(50, 400);
      return $urandom_range(3, 20);
   endfunction

   function automatic logic signed [31:0] rand_num();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 20) - 10;
         1: return 32'sh7FFF_FFFF;
         2: return -32'sh7FFF_FFFF;
         3: return $urandom_range(0, 2000) - 1000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [30:0] rand_den();
      case ($urandom_range(0, 5))
         0: return 31'($urandom_range(1, 12));
         1: return 31'h7FFF_FFFF;
         2: return 31'($urandom_range(1, 1000));
         3: return ($urandom_range(0, 40) == 0) ? 31'd0 : 31'($urandom);
         default: return 31'($urandom | 1);
      endcase
   endfunction

   task automatic send_word(int f, int ln, int ld, int rn, int rd);
      req_valid <= 1;
      req_func <= 2'(f);
      req_left_num <= ln;
      req_left_den <= 31'(ld);
      req_right_num <= rn;
      req_right_den <= 31'(rd);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic pause_sender();
      int n;
      n = gap_len();
      if (n > 0) begin
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("rational_arith_unit verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 0;
      else if ($urandom_range(0, 99) < 3) rsp_ready <= 0;
      else if (!rsp_ready) rsp_ready <= ($urandom_range(0, 3) == 0);
      else rsp_ready <= ($urandom_range(0, 9) != 0);
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int f = 0; f < 4; f++) begin
         send_word(f, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, -32'sh7FFF_FFFF, 31'h7FFF_FFFF);
         send_word(f, 3, 4, 5, 6);
         send_word(f, -7, 3, 0, 1);
         send_word(f, 32'sh8000_0000, 1, 32'sh8000_0000, 1);
         send_word(f, 32'sh7FFF_FFFF, 1, 32'sh7FFF_FFFF, 1);
      end
      send_word(FUNC_DIV, 1, 2, 0, 5);
      send_word(FUNC_ADD, 1, 0, 1, 3);
      send_word(FUNC_MUL, 4, 6, 9, 2);
      send_word(FUNC_SUB, 5, 7, 5, 7);
      send_word(FUNC_DIV, 1, 31'h7FFF_FFFF, -1, 31'h7FFF_FFFF);
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      for (int i = 0; i < 650; i++) begin
         send_word($urandom_range(0, 3), rand_num(), rand_den(), rand_num(), rand_den());
         if ($urandom_range(0, 2) == 0) pause_sender();
      end
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("sent %0d request words over all four operations, checked %0d results",
               sent, result_count);
      if (fail_count == 0)
         $display("rational_arith_unit verification clean");
      else
         $display("rational_arith_unit verification failed");
      $finish;
   end
endmodule
